// ----- hw/rtl/lobm_pkg.sv -----
// Shared types and constants of the price-level order book matcher.
// Used by lobm_ctrl, lobm_dp and the top level; depends on nothing.
`default_nettype none

package lobm_pkg;

  localparam int unsigned MAX_OUT = 64;
  localparam int unsigned NFILL_W = 7;
  localparam int unsigned LCNT_W  = 7;

  // Register index, taken from paddr[2].
  localparam logic REG_VENUE = 1'b0;

  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MATCH = 3'd1,
    OP_QUOTE = 3'd2,
    OP_DEPTH = 3'd3,
    OP_TOPN  = 3'd4,
    OP_CLEAR = 3'd5
  } op_e;

  typedef enum logic [2:0] {
    ST_INFO      = 3'd0,
    ST_SUBMITTED = 3'd1,
    ST_IGNORED   = 3'd2,
    ST_FILLED    = 3'd3,
    ST_PARTIAL   = 3'd4,
    ST_UNFILLED  = 3'd5,
    ST_REJECTED  = 3'd6
  } st_e;

  typedef enum logic [3:0] {
    EM_IGNORE,
    EM_SUBMIT,
    EM_REJECT,
    EM_FILL_INFO,
    EM_FILL_LAST,
    EM_NOFILL,
    EM_QBID,
    EM_QASK,
    EM_DEPTH,
    EM_TOPN,
    EM_CLEAR,
    EM_BADOP
  } emit_e;

  typedef enum logic [2:0] {
    RD_IDX,
    RD_PREV,
    RD_OPP,
    RD_BID,
    RD_ASK
  } rd_sel_e;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_ASCAN,
    S_ACHK,
    S_AINS,
    S_SHIFT,
    S_SHWR,
    S_SCAN,
    S_SCHK,
    S_MTEST,
    S_MDATA,
    S_MFIN,
    S_QRD0,
    S_QE0,
    S_QRD1,
    S_QE1,
    S_EMIT
  } state_e;

  typedef struct packed {
    logic [2:0]        op;
    logic              side;
    logic              is_limit;
    logic [31:0]       price;
    logic [31:0]       quantity;
    logic [31:0]       filled_before;
    logic [31:0]       order_id;
    logic [63:0]       timestamp;
    logic [LCNT_W-1:0] level_count;
  } item_t;

  typedef struct packed {
    logic [31:0] order_id;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [63:0] time_stamp;
    logic [2:0]  status;
    logic        found;
    logic        last;
  } res_t;

  typedef struct packed {
    logic    load;
    logic    idx_inc;
    logic    pos_cap;
    logic    idx_set_used;
    logic    add_upd;
    logic    shift_wr;
    logic    ins_wr;
    logic    m_fill;
    logic    topn_acc;
    logic    depth_hit;
    logic    clear;
    logic    re;
    rd_sel_e rd_sel;
    logic    emit;
    emit_e   emit_kind;
  } cmd_t;

  typedef struct packed {
    op_e  op;
    logic lim;
    logic scan_end;
    logic hit_eq;
    logic hit_pos;
    logic full;
    logic shift_done;
    logic m_more;
    logic m_cross;
    logic pend_v;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

// ----- hw/rtl/lobm_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Holds the price-level tables; no dependencies.
`default_nettype none

module lobm_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AddrW = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AddrW-1:0] waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AddrW-1:0] raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/lobm_ctrl.sv -----
// Sequencer of the order book matcher: walks each operation through its steps.
// Depends on lobm_pkg; drives the datapath by command and reads its status.
`default_nettype none

module lobm_ctrl import lobm_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_valid_i,
  output logic      s_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;
  emit_e  kind_q, kind_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      kind_q  <= EM_BADOP;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
    end
  end

  always_comb begin
    cmd_o     = '0;
    state_d   = state_q;
    kind_d    = kind_q;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.op) inside
          OP_ADD: begin
            if (!sts_i.lim) begin
              kind_d  = EM_IGNORE;
              state_d = S_EMIT;
            end else begin
              state_d = S_ASCAN;
            end
          end
          OP_MATCH: state_d = S_MTEST;
          OP_QUOTE: state_d = S_QRD0;
          OP_DEPTH, OP_TOPN: state_d = S_SCAN;
          OP_CLEAR: begin
            cmd_o.clear = 1'b1;
            kind_d      = EM_CLEAR;
            state_d     = S_EMIT;
          end
          default: begin
            kind_d  = EM_BADOP;
            state_d = S_EMIT;
          end
        endcase
      end
      S_ASCAN: begin
        if (sts_i.scan_end) begin
          cmd_o.pos_cap = 1'b1;
          state_d       = S_AINS;
        end else begin
          cmd_o.re     = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_ACHK;
        end
      end
      S_ACHK: begin
        if (sts_i.hit_eq) begin
          cmd_o.add_upd = 1'b1;
          kind_d        = EM_SUBMIT;
          state_d       = S_EMIT;
        end else if (sts_i.hit_pos) begin
          cmd_o.pos_cap = 1'b1;
          state_d       = S_AINS;
        end else begin
          cmd_o.idx_inc = 1'b1;
          state_d       = S_ASCAN;
        end
      end
      S_AINS: begin
        if (sts_i.full) begin
          kind_d  = EM_REJECT;
          state_d = S_EMIT;
        end else begin
          cmd_o.idx_set_used = 1'b1;
          state_d            = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_done) begin
          cmd_o.ins_wr = 1'b1;
          kind_d       = EM_SUBMIT;
          state_d      = S_EMIT;
        end else begin
          cmd_o.re     = 1'b1;
          cmd_o.rd_sel = RD_PREV;
          state_d      = S_SHWR;
        end
      end
      S_SHWR: begin
        cmd_o.shift_wr = 1'b1;
        state_d        = S_SHIFT;
      end
      S_SCAN: begin
        if (sts_i.scan_end) begin
          kind_d  = (sts_i.op == OP_DEPTH) ? EM_DEPTH : EM_TOPN;
          state_d = S_EMIT;
        end else begin
          cmd_o.re     = 1'b1;
          cmd_o.rd_sel = RD_IDX;
          state_d      = S_SCHK;
        end
      end
      S_SCHK: begin
        if (sts_i.op == OP_DEPTH) begin
          if (sts_i.hit_eq) begin
            cmd_o.depth_hit = 1'b1;
            kind_d          = EM_DEPTH;
            state_d         = S_EMIT;
          end else begin
            cmd_o.idx_inc = 1'b1;
            state_d       = S_SCAN;
          end
        end else begin
          cmd_o.topn_acc = 1'b1;
          cmd_o.idx_inc  = 1'b1;
          state_d        = S_SCAN;
        end
      end
      S_MTEST: begin
        if (sts_i.m_more) begin
          cmd_o.re     = 1'b1;
          cmd_o.rd_sel = RD_OPP;
          state_d      = S_MDATA;
        end else begin
          state_d = S_MFIN;
        end
      end
      S_MDATA: begin
        if (!sts_i.m_cross) begin
          state_d = S_MFIN;
        end else if (!(sts_i.pend_v && !sts_i.out_free)) begin
          // The previous fill leaves as a non-final result once a new one is known.
          cmd_o.m_fill    = 1'b1;
          cmd_o.emit      = sts_i.pend_v;
          cmd_o.emit_kind = EM_FILL_INFO;
          state_d         = S_MTEST;
        end
      end
      S_MFIN: begin
        kind_d  = sts_i.pend_v ? EM_FILL_LAST : EM_NOFILL;
        state_d = S_EMIT;
      end
      S_QRD0: begin
        cmd_o.re     = 1'b1;
        cmd_o.rd_sel = RD_BID;
        state_d      = S_QE0;
      end
      S_QE0: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_QBID;
          state_d         = S_QRD1;
        end
      end
      S_QRD1: begin
        cmd_o.re     = 1'b1;
        cmd_o.rd_sel = RD_ASK;
        state_d      = S_QE1;
      end
      S_QE1: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = EM_QASK;
          state_d         = S_IDLE;
        end
      end
      S_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_kind = kind_q;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// ----- hw/rtl/lobm_dp.sv -----
// Datapath of the order book matcher: level tables, counters and result register.
// Depends on lobm_pkg and lobm_ram; obeys commands from lobm_ctrl.
`default_nettype none

module lobm_dp import lobm_pkg::*; #(
  parameter int unsigned LEVELS     = 64,
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned QTY_BITS   = 32
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire item_t item_i,
  input  wire cmd_t  cmd_i,
  output sts_t       sts_o,
  input  wire logic  m_ready_i,
  output logic       out_valid_o,
  output res_t       res_o
);

  localparam int unsigned AW = $clog2(LEVELS);
  localparam int unsigned UW = AW + 1;
  localparam int unsigned PW = PRICE_BITS;
  localparam int unsigned QW = QTY_BITS;
  localparam int unsigned DW = PW + QW;
  localparam int unsigned CW = (UW > LCNT_W) ? UW : LCNT_W;

  function automatic logic [AW-1:0] wrap(input logic [AW-1:0] h, input logic [UW-1:0] i);
    logic [UW-1:0] s;
    s = UW'(h) + i;
    if (s >= UW'(LEVELS)) begin
      s = s - UW'(LEVELS);
    end
    return s[AW-1:0];
  endfunction

  function automatic logic [QW-1:0] qsum(input logic [QW-1:0] a, input logic [QW-1:0] b);
    logic [QW:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[QW] ? {QW{1'b1}} : s[QW-1:0];
  endfunction

  op_e               op_q;
  logic              side_q, lim_q;
  logic [PW-1:0]     price_q, best_q, pend_price_q;
  logic [QW-1:0]     rem_q, filled_q, acc_q, pend_qty_q;
  logic [31:0]       id_q;
  logic [63:0]       tm_q;
  logic [LCNT_W-1:0] nreq_q;
  logic [UW-1:0]     idx_q, pos_q;
  logic              found_q, pend_v_q;
  logic [NFILL_W-1:0] nfill_q;
  logic [AW-1:0]     head_q [2];
  logic [UW-1:0]     used_q [2];
  logic              out_valid_q;
  res_t              res_q, res_d;

  logic          sd, os;
  logic [DW-1:0] rdata, wdata;
  logic [PW-1:0] rprice;
  logic [QW-1:0] rsize, fill, newsz;
  logic [AW:0]   phys_idx, phys_prev, opp_head, raddr, waddr;
  logic          we, out_free;
  logic [UW-1:0] used_sd, used_os;
  logic [CW-1:0] idx_c, nreq_c;
  st_e           st_final;
  logic [PW-1:0] empty_sd;

  assign sd        = side_q;
  assign os        = ~side_q;
  assign rprice    = rdata[PW-1:0];
  assign rsize     = rdata[DW-1:PW];
  assign used_sd   = used_q[sd];
  assign used_os   = used_q[os];
  assign phys_idx  = {sd, wrap(head_q[sd], idx_q)};
  assign phys_prev = {sd, wrap(head_q[sd], idx_q - UW'(1))};
  assign opp_head  = {os, head_q[os]};
  assign fill      = (rem_q < rsize) ? rem_q : rsize;
  assign newsz     = rsize - fill;
  assign out_free  = !out_valid_q || m_ready_i;
  assign idx_c     = CW'(idx_q);
  assign nreq_c    = CW'(nreq_q);
  assign empty_sd  = sd ? {PW{1'b1}} : '0;

  always_comb begin
    unique case (cmd_i.rd_sel)
      RD_IDX:  raddr = phys_idx;
      RD_PREV: raddr = phys_prev;
      RD_OPP:  raddr = opp_head;
      RD_BID:  raddr = {1'b0, head_q[0]};
      RD_ASK:  raddr = {1'b1, head_q[1]};
      default: raddr = phys_idx;
    endcase
  end

  always_comb begin
    we    = 1'b0;
    waddr = phys_idx;
    wdata = rdata;
    if (cmd_i.add_upd) begin
      we    = 1'b1;
      wdata = {qsum(rsize, rem_q), rprice};
    end else if (cmd_i.shift_wr) begin
      we = 1'b1;
    end else if (cmd_i.ins_wr) begin
      we    = 1'b1;
      wdata = {rem_q, price_q};
    end else if (cmd_i.m_fill) begin
      we    = (newsz != '0);
      waddr = opp_head;
      wdata = {newsz, rprice};
    end
  end

  lobm_ram #(
    .WIDTH(DW),
    .DEPTH(2 << AW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (cmd_i.re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // Status toward the sequencer.
  always_comb begin
    sts_o.op         = op_q;
    sts_o.lim        = lim_q;
    sts_o.scan_end   = (idx_q == used_sd) ||
                       (op_q == OP_TOPN && idx_c == nreq_c && idx_q != '0);
    sts_o.hit_eq     = (rprice == price_q);
    sts_o.hit_pos    = sd ? (rprice > price_q) : (rprice < price_q);
    sts_o.full       = (used_sd >= UW'(LEVELS));
    sts_o.shift_done = (idx_q == pos_q);
    sts_o.m_more     = (used_os != '0) && (rem_q != '0) &&
                       (nfill_q < NFILL_W'(MAX_OUT));
    sts_o.m_cross    = !lim_q || (sd ? (price_q <= rprice) : (price_q >= rprice));
    sts_o.pend_v     = pend_v_q;
    sts_o.out_free   = out_free;
  end

  always_comb begin
    if (rem_q == '0) begin
      st_final = ST_FILLED;
    end else if (filled_q != '0) begin
      st_final = ST_PARTIAL;
    end else begin
      st_final = ST_UNFILLED;
    end
  end

  // Result fields for each kind of emitted result.
  always_comb begin
    res_d            = '0;
    res_d.order_id   = id_q;
    res_d.time_stamp = tm_q;
    res_d.side       = sd;
    res_d.price      = 32'(price_q);
    res_d.last       = 1'b1;
    res_d.status     = ST_INFO;
    case (cmd_i.emit_kind)
      EM_IGNORE: res_d.status = ST_IGNORED;
      EM_SUBMIT: begin
        res_d.status   = ST_SUBMITTED;
        res_d.quantity = 32'(acc_q);
        res_d.found    = 1'b1;
      end
      EM_REJECT: res_d.status = ST_REJECTED;
      EM_FILL_INFO, EM_FILL_LAST: begin
        res_d.price    = 32'(pend_price_q);
        res_d.quantity = 32'(pend_qty_q);
        res_d.found    = 1'b1;
        res_d.last     = (cmd_i.emit_kind == EM_FILL_LAST);
        res_d.status   = (cmd_i.emit_kind == EM_FILL_LAST) ? st_final : ST_INFO;
      end
      EM_NOFILL: res_d.status = st_final;
      EM_QBID: begin
        res_d.side     = 1'b0;
        res_d.found    = (used_q[0] != '0);
        res_d.price    = res_d.found ? 32'(rprice) : '0;
        res_d.quantity = res_d.found ? 32'(rsize) : '0;
        res_d.last     = 1'b0;
      end
      EM_QASK: begin
        res_d.side     = 1'b1;
        res_d.found    = (used_q[1] != '0);
        res_d.price    = res_d.found ? 32'(rprice) : 32'({PW{1'b1}});
        res_d.quantity = res_d.found ? 32'(rsize) : '0;
      end
      EM_DEPTH: begin
        res_d.quantity = 32'(acc_q);
        res_d.found    = found_q;
      end
      EM_TOPN: begin
        res_d.found    = (used_sd != '0);
        res_d.price    = res_d.found ? 32'(best_q) : 32'(empty_sd);
        res_d.quantity = 32'(acc_q);
      end
      EM_CLEAR: begin
        res_d.side  = 1'b0;
        res_d.price = '0;
      end
      default: begin
        res_d.side   = 1'b0;
        res_d.price  = '0;
        res_d.status = ST_IGNORED;
      end
    endcase
  end

  // Control state: table occupancy, ring heads, output valid and pending fill flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < 2; s++) begin
        head_q[s] <= '0;
        used_q[s] <= '0;
      end
      out_valid_q <= 1'b0;
      pend_v_q    <= 1'b0;
    end else begin
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.load) begin
        pend_v_q <= 1'b0;
      end else if (cmd_i.m_fill) begin
        pend_v_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        used_q[0] <= '0;
        used_q[1] <= '0;
      end
      if (cmd_i.ins_wr) begin
        used_q[sd] <= used_sd + UW'(1);
      end
      if (cmd_i.m_fill && newsz == '0) begin
        head_q[os] <= wrap(head_q[os], UW'(1));
        used_q[os] <= used_os - UW'(1);
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      res_q <= res_d;
    end
    if (cmd_i.load) begin
      op_q     <= op_e'(item_i.op);
      side_q   <= item_i.side;
      lim_q    <= item_i.is_limit;
      price_q  <= PW'(item_i.price);
      rem_q    <= QW'(item_i.quantity);
      filled_q <= QW'(item_i.filled_before);
      id_q     <= item_i.order_id;
      tm_q     <= item_i.timestamp;
      nreq_q   <= item_i.level_count;
      idx_q    <= '0;
      acc_q    <= '0;
      found_q  <= 1'b0;
      nfill_q  <= '0;
    end else begin
      if (cmd_i.idx_inc) begin
        idx_q <= idx_q + UW'(1);
      end
      if (cmd_i.idx_set_used) begin
        idx_q <= used_sd;
      end
      if (cmd_i.shift_wr) begin
        idx_q <= idx_q - UW'(1);
      end
      if (cmd_i.pos_cap) begin
        pos_q <= idx_q;
      end
      if (cmd_i.add_upd) begin
        acc_q <= qsum(rsize, rem_q);
      end
      if (cmd_i.ins_wr) begin
        acc_q <= rem_q;
      end
      if (cmd_i.depth_hit) begin
        acc_q   <= rsize;
        found_q <= 1'b1;
      end
      if (cmd_i.topn_acc) begin
        if (idx_c < nreq_c) begin
          acc_q <= qsum(acc_q, rsize);
        end
        if (idx_q == '0) begin
          best_q <= rprice;
        end
      end
      if (cmd_i.m_fill) begin
        rem_q        <= rem_q - fill;
        filled_q     <= qsum(filled_q, fill);
        pend_price_q <= rprice;
        pend_qty_q   <= fill;
        nfill_q      <= nfill_q + NFILL_W'(1);
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ----- hw/rtl/limit_order_book_matcher_top.sv -----
// Top level of the price-level limit order book matcher.
// Depends on lobm_pkg, lobm_ctrl, lobm_dp (which holds lobm_ram).
//
// Usage: orders and queries arrive on the s_axis channel, one transaction per
// item; tuser carries the operation code. Each item produces one or more result
// transactions on m_axis, the final one flagged by tlast. The venue tag is to be
// set through the APB port while the block is idle; the block does not enforce
// this. The tag is stamped on every result. Bid and ask levels live in one RAM,
// each side kept as a ring of sorted levels so that removing the best level
// only moves the ring head. One item is in work at a time; s_axis_tready is high
// only when the sequencer is idle. The RAM read is registered, so each table
// step reads and then checks: an add scans and then shifts levels, a match
// walks the opposite side, a quote reads both best levels, depth queries scan
// one side. A single output register decouples the two sides: the next item is
// accepted while the last result of the previous one waits. When the receiver
// stalls, the sequencer holds in the step that emits and no work is lost. Reset
// empties both sides and clears the venue tag; the table RAM itself is not
// cleared, no pass over it is needed since only occupied levels are read.
`default_nettype none

module limit_order_book_matcher_top import lobm_pkg::*; #(
  parameter int unsigned LEVELS     = 64,
  parameter int unsigned PRICE_BITS = 32,
  parameter int unsigned QTY_BITS   = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  // side[0], is_limit[1], price[33:2], quantity[65:34], filled_before[97:66],
  // order_id[129:98], timestamp[193:130], level_count[200:194], zero fill above
  input  wire logic [207:0] s_axis_tdata_i,
  // operation[2:0]
  input  wire logic [2:0]   s_axis_tuser_i,
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // result_order_id[31:0], result_venue[39:32], result_side[40],
  // result_price[72:41], result_quantity[104:73], result_time[168:105],
  // level_found[169], zero fill above
  output logic [175:0]      m_axis_tdata_o,
  // order_status[2:0]
  output logic [2:0]        m_axis_tuser_o,
  output logic              m_axis_tlast_o,
  input  wire logic         psel_i,
  input  wire logic         penable_i,
  input  wire logic         pwrite_i,
  input  wire logic [2:0]   paddr_i,
  input  wire logic [31:0]  pwdata_i,
  output logic [31:0]       prdata_o,
  output logic              pready_o
);

  logic [7:0] venue_q;
  item_t      item;
  cmd_t       cmd;
  sts_t       sts;
  res_t       res;
  logic       out_valid;

  // The only register is the venue tag, at byte address zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      venue_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && paddr_i[2] == REG_VENUE) begin
      venue_q <= pwdata_i[7:0];
    end
  end

  assign pready_o = 1'b1;
  assign prdata_o = (paddr_i[2] == REG_VENUE) ? 32'(venue_q) : '0;

  assign item.op            = s_axis_tuser_i;
  assign item.side          = s_axis_tdata_i[0];
  assign item.is_limit      = s_axis_tdata_i[1];
  assign item.price         = s_axis_tdata_i[33:2];
  assign item.quantity      = s_axis_tdata_i[65:34];
  assign item.filled_before = s_axis_tdata_i[97:66];
  assign item.order_id      = s_axis_tdata_i[129:98];
  assign item.timestamp     = s_axis_tdata_i[193:130];
  assign item.level_count   = s_axis_tdata_i[200:194];

  lobm_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .s_valid_i(s_axis_tvalid_i),
    .s_ready_o(s_axis_tready_o),
    .sts_i    (sts),
    .cmd_o    (cmd)
  );

  lobm_dp #(
    .LEVELS    (LEVELS),
    .PRICE_BITS(PRICE_BITS),
    .QTY_BITS  (QTY_BITS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .m_ready_i  (m_axis_tready_i),
    .out_valid_o(out_valid),
    .res_o      (res)
  );

  assign m_axis_tvalid_o = out_valid;
  assign m_axis_tdata_o  = {6'b0, res.found, res.time_stamp, res.quantity, res.price,
                            res.side, venue_q, res.order_id};
  assign m_axis_tuser_o  = res.status;
  assign m_axis_tlast_o  = res.last;

endmodule

`default_nettype wire

// ----- hw/rtl/lobm_checker.sv -----
// Port-level checks of the order book matcher, bound to its top level.
// Depends only on the top level's ports.
`default_nettype none

module lobm_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid_i,
  input wire logic         s_axis_tready_o,
  input wire logic         m_axis_tvalid_o,
  input wire logic         m_axis_tready_i,
  input wire logic         m_axis_tlast_o,
  input wire logic [175:0] m_axis_tdata_o,
  input wire logic         pready_o
);

  // A result held back by the receiver stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o))
    else $error("result withdrawn or changed while stalled");

  // Only one item is in work: after a transaction the input closes.
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("second item taken while one is in work");

  // No result is offered straight out of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !m_axis_tvalid_o)
    else $error("result offered out of reset");

  // The configuration port never waits.
  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready_o)
    else $error("pready low");

endmodule

bind limit_order_book_matcher_top lobm_checker u_lobm_checker (.*);

`default_nettype wire

// ----- tb/sv/tb_limit_order_book_matcher_top.sv -----
// Self-checking testbench for the price-level limit order book matcher.
// Needs lobm_pkg and limit_order_book_matcher_top; it reads nothing else.
// A local book model predicts every result, which is checked in order.
`default_nettype none

module tb_limit_order_book_matcher_top;
  import lobm_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Codes outside the defined operation set, which the block must ignore.
  localparam logic [2:0] OP_BAD_LO = 3'd6;
  localparam logic [2:0] OP_BAD_HI = 3'd7;
  localparam logic [2:0] ADDR_VENUE = {REG_VENUE, 2'b00};
  localparam int unsigned BOOK_DEPTH = 64;
  localparam longint unsigned CYCLE_LIMIT = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 300;

  // One expected result transaction on the master side.
  typedef struct {
    logic [31:0] order_id;
    logic [7:0]  venue;
    logic        side;
    logic [31:0] price;
    logic [31:0] quantity;
    logic [63:0] stamp;
    logic [2:0]  status;
    logic        found;
    logic        last;
  } fill_rec_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid_i;
  logic         s_axis_tready_o;
  logic [207:0] s_axis_tdata_i;
  logic [2:0]   s_axis_tuser_i;
  logic         m_axis_tvalid_o;
  logic         m_axis_tready_i;
  logic [175:0] m_axis_tdata_o;
  logic [2:0]   m_axis_tuser_o;
  logic         m_axis_tlast_o;
  logic         psel_i;
  logic         penable_i;
  logic         pwrite_i;
  logic [2:0]   paddr_i;
  logic [31:0]  pwdata_i;
  logic [31:0]  prdata_o;
  logic         pready_o;

  limit_order_book_matcher_top u_dut (.*);

  // The predicted book: index 0 holds bids (best first, descending), index 1
  // holds asks (best first, ascending).
  logic [31:0] book_px[0:1][0:BOOK_DEPTH-1];
  logic [31:0] book_sz[0:1][0:BOOK_DEPTH-1];
  int unsigned book_used[0:1];
  logic [7:0]  venue_model;

  fill_rec_t   pending_results[$];
  int unsigned mismatches;
  int unsigned results_seen;
  int unsigned items_sent;
  longint unsigned cycles;

  bit          idle_en;
  int unsigned hold_left;
  int unsigned stall_left;

  // 100 MHz clock.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Watchdog: a run that hangs ends as a failure.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("Test completed with failures");
      $finish;
    end
  end

  // Receiver side. A long hold-off requested by a test takes priority over the
  // short random stall bursts; during the final part no stalls occur at all.
  initial begin
    m_axis_tready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        m_axis_tready_i <= 1'b0;
        hold_left--;
      end else if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left = $urandom_range(0, 3);
      end else begin
        m_axis_tready_i <= 1'b1;
      end
    end
  end

  // Result checker: every transaction on the master side is compared field
  // by field with the oldest predicted result.
  always @(posedge clk_i) begin
    fill_rec_t exp_r;
    bit        bad;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("Unexpected result transaction: tdata=%h tuser=%0d tlast=%b",
                   m_axis_tdata_o, m_axis_tuser_o, m_axis_tlast_o);
      end else begin
        exp_r = pending_results.pop_front();
        bad = (m_axis_tdata_o[31:0]    !== exp_r.order_id) ||
              (m_axis_tdata_o[39:32]   !== exp_r.venue)    ||
              (m_axis_tdata_o[40]      !== exp_r.side)     ||
              (m_axis_tdata_o[72:41]   !== exp_r.price)    ||
              (m_axis_tdata_o[104:73]  !== exp_r.quantity) ||
              (m_axis_tdata_o[168:105] !== exp_r.stamp)    ||
              (m_axis_tdata_o[169]     !== exp_r.found)    ||
              (m_axis_tuser_o          !== exp_r.status)   ||
              (m_axis_tlast_o          !== exp_r.last);
        if (bad) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("Mismatch on result %0d at cycle %0d", results_seen, cycles);
            $display("  expected id=%h venue=%h side=%b px=%h qty=%h t=%h st=%0d fnd=%b last=%b",
                     exp_r.order_id, exp_r.venue, exp_r.side, exp_r.price,
                     exp_r.quantity, exp_r.stamp, exp_r.status, exp_r.found,
                     exp_r.last);
            $display("  actual   id=%h venue=%h side=%b px=%h qty=%h t=%h st=%0d fnd=%b last=%b",
                     m_axis_tdata_o[31:0], m_axis_tdata_o[39:32], m_axis_tdata_o[40],
                     m_axis_tdata_o[72:41], m_axis_tdata_o[104:73],
                     m_axis_tdata_o[168:105], m_axis_tuser_o, m_axis_tdata_o[169],
                     m_axis_tlast_o);
          end
        end
      end
    end
  end

  // Saturating quantity sum.
  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic logic [31:0] empty_px(logic sd);
    return sd ? 32'hFFFF_FFFF : 32'h0;
  endfunction

  task automatic push_result(logic [31:0] id, logic sd, logic [31:0] px, logic [31:0] qty,
                             logic [63:0] ts, logic [2:0] st, logic fnd, logic lst);
    fill_rec_t r;
    r.order_id = id;
    r.venue    = venue_model;
    r.side     = sd;
    r.price    = px;
    r.quantity = qty;
    r.stamp    = ts;
    r.status   = st;
    r.found    = fnd;
    r.last     = lst;
    pending_results.push_back(r);
  endtask

  // Removes the best level of one side by shifting the rest up.
  task automatic drop_best(int s);
    for (int j = 0; j + 1 < book_used[s]; j++) begin
      book_px[s][j] = book_px[s][j+1];
      book_sz[s][j] = book_sz[s][j+1];
    end
    book_used[s]--;
  endtask

  // Applies one accepted item to the predicted book and queues its results.
  task automatic predict_book_step(logic [2:0] op, logic sd, logic lim, logic [31:0] px,
                                   logic [31:0] qty, logic [31:0] fb, logic [31:0] id,
                                   logic [63:0] ts, logic [6:0] lcnt);
    int          s;
    int          o;
    int          pos;
    bit          hit;
    int          n;
    logic [31:0] rem;
    logic [31:0] filled;
    logic [31:0] lp;
    logic [31:0] f;
    logic [31:0] tot;
    logic [2:0]  st;
    s = sd;
    o = !sd;
    case (op)
      OP_ADD: begin
        if (!lim) begin
          push_result(id, sd, px, 0, ts, ST_IGNORED, 0, 1);
        end else begin
          pos = book_used[s];
          hit = 0;
          for (int j = 0; j < book_used[s]; j++) begin
            if (book_px[s][j] == px) begin
              pos = j;
              hit = 1;
              break;
            end
            if (sd ? (book_px[s][j] > px) : (book_px[s][j] < px)) begin
              pos = j;
              break;
            end
          end
          if (hit) begin
            book_sz[s][pos] = sat_add(book_sz[s][pos], qty);
            push_result(id, sd, px, book_sz[s][pos], ts, ST_SUBMITTED, 1, 1);
          end else if (book_used[s] >= BOOK_DEPTH) begin
            push_result(id, sd, px, 0, ts, ST_REJECTED, 0, 1);
          end else begin
            for (int j = book_used[s]; j > pos; j--) begin
              book_px[s][j] = book_px[s][j-1];
              book_sz[s][j] = book_sz[s][j-1];
            end
            book_px[s][pos] = px;
            book_sz[s][pos] = qty;
            book_used[s]++;
            push_result(id, sd, px, qty, ts, ST_SUBMITTED, 1, 1);
          end
        end
      end
      OP_MATCH: begin
        rem = qty;
        filled = fb;
        n = 0;
        while (book_used[o] > 0 && rem > 0 && n < MAX_OUT) begin
          lp = book_px[o][0];
          if (lim && (sd ? (px > lp) : (px < lp))) break;
          f = (rem < book_sz[o][0]) ? rem : book_sz[o][0];
          book_sz[o][0] -= f;
          rem -= f;
          filled = sat_add(filled, f);
          push_result(id, sd, lp, f, ts, ST_INFO, 1, 0);
          n++;
          if (book_sz[o][0] == 0) drop_best(o);
        end
        st = (rem == 0) ? ST_FILLED : ((filled != 0) ? ST_PARTIAL : ST_UNFILLED);
        if (n == 0) begin
          push_result(id, sd, px, 0, ts, st, 0, 1);
        end else begin
          pending_results[pending_results.size()-1].status = st;
          pending_results[pending_results.size()-1].last = 1'b1;
        end
      end
      OP_QUOTE: begin
        for (int q = 0; q < 2; q++) begin
          if (book_used[q] > 0)
            push_result(id, q[0], book_px[q][0], book_sz[q][0], ts, ST_INFO, 1, q == 1);
          else
            push_result(id, q[0], empty_px(q[0]), 0, ts, ST_INFO, 0, q == 1);
        end
      end
      OP_DEPTH: begin
        tot = 0;
        hit = 0;
        for (int j = 0; j < book_used[s]; j++) begin
          if (book_px[s][j] == px) begin
            tot = book_sz[s][j];
            hit = 1;
            break;
          end
        end
        push_result(id, sd, px, tot, ts, ST_INFO, hit, 1);
      end
      OP_TOPN: begin
        tot = 0;
        for (int j = 0; j < book_used[s] && j < lcnt; j++) tot = sat_add(tot, book_sz[s][j]);
        push_result(id, sd, (book_used[s] > 0) ? book_px[s][0] : empty_px(sd), tot, ts,
                    ST_INFO, book_used[s] > 0, 1);
      end
      OP_CLEAR: begin
        book_used[0] = 0;
        book_used[1] = 0;
        push_result(id, 0, 0, 0, ts, ST_INFO, 0, 1);
      end
      default: push_result(id, 0, 0, 0, ts, ST_IGNORED, 0, 1);
    endcase
  endtask

  // Offers one item on the slave side, with an optional random gap first, and
  // predicts its results once the transaction is accepted. Valid stays high
  // afterwards so that back-to-back items need no gap.
  task automatic send_order(logic [2:0] op, logic sd, logic lim, logic [31:0] px,
                            logic [31:0] qty, logic [31:0] fb, logic [31:0] id,
                            logic [63:0] ts, logic [6:0] lcnt);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= op;
    s_axis_tdata_i  <= {7'b0, lcnt, ts, id, fb, qty, px, lim, sd};
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    predict_book_step(op, sd, lim, px, qty, fb, id, ts, lcnt);
  endtask

  task automatic stop_sending();
    @(negedge clk_i);
    s_axis_tvalid_i <= 1'b0;
  endtask

  // Quick form for items whose ids and stamps do not matter.
  task automatic send_simple(logic [2:0] op, logic sd, logic lim, logic [31:0] px,
                             logic [31:0] qty);
    send_order(op, sd, lim, px, qty, 0, $urandom, {$urandom, $urandom}, 7'd64);
  endtask

  // Lets every outstanding result arrive, then a further pause so that the
  // sequencer is idle before the configuration changes.
  task automatic wait_idle();
    stop_sending();
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_venue(logic [7:0] tag);
    @(negedge clk_i);
    psel_i    <= 1'b1;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b1;
    paddr_i   <= ADDR_VENUE;
    pwdata_i  <= {24'($urandom_range(0, 16777215)), tag};
    @(negedge clk_i);
    penable_i <= 1'b1;
    do @(posedge clk_i); while (!pready_o);
    venue_model = tag;
    @(negedge clk_i);
    psel_i    <= 1'b0;
    penable_i <= 1'b0;
    pwrite_i  <= 1'b0;
  endtask

  // Queries and matches against an empty book, ignored codes and clear.
  task automatic test_empty_book();
    send_order(OP_QUOTE, 0, 0, 0, 0, 0, 32'h0, 64'h0, 0);
    send_order(OP_TOPN, 0, 1, 0, 0, 0, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 7'd64);
    send_order(OP_TOPN, 1, 1, 0, 0, 0, 32'h1, 64'h1, 7'd0);
    send_order(OP_DEPTH, 1, 1, 32'h10, 0, 0, 32'h2, 64'h2, 0);
    send_order(OP_MATCH, 0, 1, 32'hFFFF_FFFF, 32'h5, 0, 32'h3, 64'h3, 0);
    send_order(OP_MATCH, 1, 0, 32'h0, 32'h5, 32'hFFFF_FFFF, 32'h4, 64'h4, 0);
    send_order(OP_ADD, 0, 0, 32'h55, 32'h7, 0, 32'h5, 64'h5, 0);
    send_order(OP_BAD_LO, 1, 1, 32'h1, 32'h1, 0, 32'h6, 64'h6, 0);
    send_order(OP_BAD_HI, 0, 1, 32'h1, 32'h1, 0, 32'h7, 64'h7, 0);
    send_order(OP_CLEAR, 1, 1, 32'h9, 32'h9, 0, 32'h8, 64'h8, 0);
  endtask

  // Extreme prices and sizes, saturation, zero-size levels and match statuses.
  task automatic test_extremes();
    send_simple(OP_ADD, 1, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_simple(OP_ADD, 1, 1, 32'hFFFF_FFFF, 32'h10);
    send_simple(OP_ADD, 1, 1, 32'h0, 32'h0);
    send_simple(OP_ADD, 0, 1, 32'h0, 32'h3);
    send_simple(OP_ADD, 0, 1, 32'hFFFF_FFFE, 32'h4);
    send_simple(OP_QUOTE, 0, 0, 0, 0);
    send_simple(OP_TOPN, 1, 1, 0, 0);
    send_simple(OP_DEPTH, 0, 1, 32'h0, 0);
    // The zero-size ask gives a zero fill; the limit stops before the big one.
    send_order(OP_MATCH, 0, 1, 32'h7FFF_FFFF, 32'h2, 32'h0, 32'hA, 64'hA, 0);
    send_order(OP_MATCH, 1, 1, 32'h1, 32'h4, 32'h0, 32'hB, 64'hB, 0);
    send_order(OP_MATCH, 1, 0, 32'h0, 32'h9, 32'h1, 32'hC, 64'hC, 0);
    send_order(OP_MATCH, 0, 0, 32'h0, 32'h0, 32'h0, 32'hD, 64'hD, 0);
    send_order(OP_MATCH, 0, 0, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hE, 64'hE, 0);
    send_simple(OP_CLEAR, 0, 0, 0, 0);
  endtask

  // Fills the bid side completely while the receiver holds off, so that the
  // output stalls and back-pressure reaches the input, then sweeps it.
  task automatic test_full_side();
    hold_left = 400;
    for (int j = 0; j < BOOK_DEPTH; j++)
      send_simple(OP_ADD, 0, 1, 32'd100 + ((j * 37) % BOOK_DEPTH) * 3,
                  $urandom_range(1, 20));
    send_simple(OP_ADD, 0, 1, 32'd101, 32'd5);
    send_simple(OP_ADD, 0, 1, 32'd103, 32'd5);
    send_simple(OP_ADD, 0, 1, 32'd100, 32'd5);
    send_order(OP_TOPN, 0, 1, 0, 0, 0, $urandom, 64'h0, 7'd64);
    send_order(OP_TOPN, 0, 1, 0, 0, 0, $urandom, 64'h0, 7'd5);
    send_simple(OP_DEPTH, 0, 1, 32'd100, 0);
    send_order(OP_MATCH, 1, 0, 0, 32'hFFFF_FFFF, 0, $urandom, 64'h0, 0);
    send_simple(OP_QUOTE, 0, 0, 0, 0);
  endtask

  // Mostly well-formed orders in a narrow price band so that matches cross,
  // with some fully random items mixed in.
  task automatic test_random_flow(int unsigned count);
    int unsigned roll;
    logic [2:0]  op;
    logic        sd;
    logic        lim;
    logic [31:0] px;
    logic [31:0] qty;
    logic [31:0] fb;
    for (int unsigned k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) op = OP_ADD;
      else if (roll < 70) op = OP_MATCH;
      else if (roll < 78) op = OP_QUOTE;
      else if (roll < 86) op = OP_DEPTH;
      else if (roll < 94) op = OP_TOPN;
      else if (roll < 97) op = OP_CLEAR;
      else op = $urandom_range(0, 1) ? OP_BAD_LO : OP_BAD_HI;
      sd  = $urandom_range(0, 1);
      lim = $urandom_range(0, 99) < 85;
      px  = ($urandom_range(0, 19) == 0) ? $urandom : 32'd1000 + $urandom_range(0, 15);
      qty = ($urandom_range(0, 19) == 0) ? $urandom : $urandom_range(0, 50);
      fb  = ($urandom_range(0, 4) == 0) ? $urandom : 32'h0;
      send_order(op, sd, lim, px, qty, fb, $urandom, {$urandom, $urandom},
                 7'($urandom_range(0, 64)));
    end
  endtask

  initial begin
    rst_ni          = 1'b0;
    s_axis_tvalid_i = 1'b0;
    s_axis_tdata_i  = '0;
    s_axis_tuser_i  = OP_ADD;
    psel_i          = 1'b0;
    penable_i       = 1'b0;
    pwrite_i        = 1'b0;
    paddr_i         = '0;
    pwdata_i        = '0;
    book_used[0]    = 0;
    book_used[1]    = 0;
    venue_model     = '0;
    mismatches      = 0;
    results_seen    = 0;
    items_sent      = 0;
    cycles          = 0;
    idle_en         = 1'b1;
    hold_left       = 0;
    stall_left      = 0;
    repeat (8) @(negedge clk_i);
    rst_ni = 1'b1;

    // The venue tag starts from its reset value of zero.
    test_empty_book();
    wait_idle();
    write_venue(8'hFF);
    test_extremes();
    wait_idle();
    write_venue(8'hA5);
    test_full_side();
    wait_idle();
    write_venue(8'h00);
    test_random_flow(50);
    wait_idle();
    write_venue(8'($urandom_range(1, 254)));
    test_random_flow(50);
    wait_idle();
    write_venue(8'h5A);
    // The final stretch runs without any idling on either side.
    idle_en = 1'b0;
    test_random_flow(34);
    wait_idle();

    $display("Sent %0d items and checked %0d results, covering empty-book queries,",
             items_sent, results_seen);
    $display("extreme values, a full side with a long output stall, and random trading.");
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_results.size());
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

`default_nettype wire
